// ===== src/fhc_pkg.sv =====
// Package: shared types, constants and the byte-wide CRC-32 step for the frame header checker.
`timescale 1ns / 1ps

package fhc_pkg;

    // Header layout, in byte positions from the frame start
    localparam logic [4:0] POS_VERSION  = 5'd4;
    localparam logic [4:0] POS_TYPE     = 5'd6;
    localparam logic [4:0] POS_FLAGS    = 5'd8;
    localparam logic [4:0] POS_RESERVED = 5'd10;
    localparam logic [4:0] POS_LENGTH   = 5'd12;
    localparam logic [4:0] POS_CRC      = 5'd16;
    localparam logic [4:0] POS_SEQUENCE = 5'd20;
    localparam logic [4:0] HDR_BYTES    = 5'd28;

    // Payload byte counter saturates at its all-ones value
    localparam logic [32:0] COUNT_MAX = {33{1'b1}};

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [15:0] TYPE_MIN = 16'd1;
    localparam logic [15:0] TYPE_MAX = 16'd9;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_MAGIC       = 2'd0;
    localparam logic [1:0]  CFG_VERSION     = 2'd1;
    localparam logic [1:0]  CFG_MAX_PAYLOAD = 2'd2;
    localparam logic [31:0] MAGIC_RESET       = 32'd0;
    localparam logic [15:0] VERSION_RESET     = 16'd1;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_VERSION  = 3'd3,
        ST_TYPE     = 3'd4,
        ST_OVERSIZE = 3'd5,
        ST_CRC      = 3'd6
    } status_t;

    // One frame byte as held in the input stage
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } item_t;

    // One frame report
    typedef struct packed {
        status_t     status;
        logic [15:0] frame_type;
        logic [15:0] frame_flags;
        logic [31:0] payload_length;
        logic [31:0] declared_crc;
        logic [63:0] frame_sequence;
    } result_t;

    // Reflected CRC-32 over one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

// ===== src/fhc_in_stage.sv =====
// Input register stage: holds one accepted byte until the frame logic takes it.
`timescale 1ns / 1ps

module fhc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     data_byte,
    input  logic           frame_end,
    input  logic           advance,
    output logic           held_valid,
    output fhc_pkg::item_t held_item
);

    logic           valid_reg;
    logic           valid_next;
    fhc_pkg::item_t item_reg;
    logic           accept;

    // Stall only while a held byte cannot move on this cycle
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload register, loaded on each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte <= data_byte;
            item_reg.frame_end <= frame_end;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== src/fhc_frame.sv =====
// Frame logic: header capture, magic check, payload CRC and count, status on the last byte.
`timescale 1ns / 1ps

module fhc_frame (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  fhc_pkg::item_t   item,
    input  logic [31:0]      expected_magic,
    input  logic [15:0]      expected_version,
    input  logic [31:0]      payload_limit,
    output fhc_pkg::result_t result
);

    logic [4:0]  pos_reg,      pos_next,      pos_aft;
    logic        magic_bad_reg, magic_bad_next, magic_bad_aft;
    logic [15:0] version_reg,  version_next,  version_aft;
    logic [15:0] type_reg,     type_next,     type_aft;
    logic [15:0] flags_reg,    flags_next,    flags_aft;
    logic [31:0] length_reg,   length_next,   length_aft;
    logic [31:0] crc_seen_reg, crc_seen_next, crc_seen_aft;
    logic [63:0] seq_reg,      seq_next,      seq_aft;
    logic [31:0] run_crc_reg,  run_crc_next,  run_crc_aft;
    logic [32:0] count_reg,    count_next,    count_aft;
    logic [2:0]  seq_lane;
    logic [7:0]  b;
    fhc_pkg::status_t status_c;

    assign b        = item.data_byte;
    assign seq_lane = 3'(pos_reg - fhc_pkg::POS_SEQUENCE);

    // Fold the byte into the frame state
    always_comb
    begin
        pos_aft       = pos_reg;
        magic_bad_aft = magic_bad_reg;
        version_aft   = version_reg;
        type_aft      = type_reg;
        flags_aft     = flags_reg;
        length_aft    = length_reg;
        crc_seen_aft  = crc_seen_reg;
        seq_aft       = seq_reg;
        run_crc_aft   = run_crc_reg;
        count_aft     = count_reg;
        if (pos_reg < fhc_pkg::HDR_BYTES)
        begin
            pos_aft = pos_reg + 5'd1;
            if (pos_reg < fhc_pkg::POS_VERSION)
            begin
                if (b != expected_magic[8*pos_reg[1:0] +: 8])
                    magic_bad_aft = 1'b1;
            end
            else if (pos_reg < fhc_pkg::POS_TYPE)
                version_aft[8*pos_reg[0] +: 8] = b;
            else if (pos_reg < fhc_pkg::POS_FLAGS)
                type_aft[8*pos_reg[0] +: 8] = b;
            else if (pos_reg < fhc_pkg::POS_RESERVED)
                flags_aft[8*pos_reg[0] +: 8] = b;
            else if (pos_reg < fhc_pkg::POS_LENGTH)
            begin
                // reserved bytes are dropped
            end
            else if (pos_reg < fhc_pkg::POS_CRC)
                length_aft[8*pos_reg[1:0] +: 8] = b;
            else if (pos_reg < fhc_pkg::POS_SEQUENCE)
                crc_seen_aft[8*pos_reg[1:0] +: 8] = b;
            else
                seq_aft[8*seq_lane +: 8] = b;
        end
        else
        begin
            run_crc_aft = fhc_pkg::crc32_byte(run_crc_reg, b);
            if (count_reg != fhc_pkg::COUNT_MAX)
                count_aft = count_reg + 33'd1;
        end
    end

    // Status priority, from the state after this byte
    always_comb
    begin
        if (pos_aft < fhc_pkg::HDR_BYTES)
            status_c = fhc_pkg::ST_TRUNC;
        else if (magic_bad_aft)
            status_c = fhc_pkg::ST_MAGIC;
        else if (version_aft != expected_version)
            status_c = fhc_pkg::ST_VERSION;
        else if (type_aft < fhc_pkg::TYPE_MIN || type_aft > fhc_pkg::TYPE_MAX)
            status_c = fhc_pkg::ST_TYPE;
        else if (length_aft > payload_limit)
            status_c = fhc_pkg::ST_OVERSIZE;
        else if (count_aft != {1'b0, length_aft})
            status_c = fhc_pkg::ST_TRUNC;
        else if (~run_crc_aft != crc_seen_aft)
            status_c = fhc_pkg::ST_CRC;
        else
            status_c = fhc_pkg::ST_OK;
    end

    always_comb
    begin
        result.status         = status_c;
        result.frame_type     = type_aft;
        result.frame_flags    = flags_aft;
        result.payload_length = length_aft;
        result.declared_crc   = crc_seen_aft;
        result.frame_sequence = seq_aft;
    end

    // Next state: hold, advance, or clear after the last byte
    always_comb
    begin
        pos_next       = pos_reg;
        magic_bad_next = magic_bad_reg;
        version_next   = version_reg;
        type_next      = type_reg;
        flags_next     = flags_reg;
        length_next    = length_reg;
        crc_seen_next  = crc_seen_reg;
        seq_next       = seq_reg;
        run_crc_next   = run_crc_reg;
        count_next     = count_reg;
        if (take)
        begin
            if (item.frame_end)
            begin
                pos_next       = '0;
                magic_bad_next = 1'b0;
                version_next   = '0;
                type_next      = '0;
                flags_next     = '0;
                length_next    = '0;
                crc_seen_next  = '0;
                seq_next       = '0;
                run_crc_next   = fhc_pkg::CRC_INIT;
                count_next     = '0;
            end
            else
            begin
                pos_next       = pos_aft;
                magic_bad_next = magic_bad_aft;
                version_next   = version_aft;
                type_next      = type_aft;
                flags_next     = flags_aft;
                length_next    = length_aft;
                crc_seen_next  = crc_seen_aft;
                seq_next       = seq_aft;
                run_crc_next   = run_crc_aft;
                count_next     = count_aft;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            magic_bad_reg <= 1'b0;
            version_reg   <= '0;
            type_reg      <= '0;
            flags_reg     <= '0;
            length_reg    <= '0;
            crc_seen_reg  <= '0;
            seq_reg       <= '0;
            run_crc_reg   <= fhc_pkg::CRC_INIT;
            count_reg     <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            magic_bad_reg <= magic_bad_next;
            version_reg   <= version_next;
            type_reg      <= type_next;
            flags_reg     <= flags_next;
            length_reg    <= length_next;
            crc_seen_reg  <= crc_seen_next;
            seq_reg       <= seq_next;
            run_crc_reg   <= run_crc_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== src/fhc_out_stage.sv =====
// Output register stage: holds one frame report until the receiver takes it.
`timescale 1ns / 1ps

module fhc_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fhc_pkg::result_t result_in,
    input  logic             out_stall,
    output logic             out_free,
    output logic             out_valid,
    output fhc_pkg::result_t result_out
);

    logic             valid_reg;
    logic             valid_next;
    fhc_pkg::result_t result_reg;

    // Free when empty or when the held report leaves this cycle
    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== src/frame_header_check_crc32_top.sv =====
// Frame header checker with payload CRC-32: top level.
// Timing: a transferred byte is held in the input stage and folded into the frame state when
//   it advances; the report is registered in the output stage when the last byte advances.
// Throughput: one byte per cycle, set by the byte-wide CRC step; a last byte waits
//   only while the report slot holds a report that the receiver stalls.
// Reset: rst_n clears all frame state, the valid flags of both stages and loads register defaults.
`timescale 1ns / 1ps

module frame_header_check_crc32_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] frame_type,
    output logic [15:0] frame_flags,
    output logic [31:0] payload_length,
    output logic [31:0] declared_crc,
    output logic [63:0] frame_sequence
);

    logic [31:0] magic_reg;
    logic [15:0] version_reg;
    logic [31:0] max_payload_reg;

    logic             held_valid;
    fhc_pkg::item_t   held_item;
    logic             advance;
    logic             out_free;
    logic             load;
    fhc_pkg::result_t frame_result;
    fhc_pkg::result_t out_result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg       <= fhc_pkg::MAGIC_RESET;
            version_reg     <= fhc_pkg::VERSION_RESET;
            max_payload_reg <= fhc_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fhc_pkg::CFG_MAGIC:       magic_reg       <= cfg_data;
                fhc_pkg::CFG_VERSION:     version_reg     <= cfg_data[15:0];
                fhc_pkg::CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // A byte moves on unless it ends a frame and the report slot is busy
    assign advance = held_valid && (!held_item.frame_end || out_free);
    assign load    = advance && held_item.frame_end;

    fhc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .frame_end  (frame_end),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    fhc_frame u_frame (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (advance),
        .item             (held_item),
        .expected_magic   (magic_reg),
        .expected_version (version_reg),
        .payload_limit    (max_payload_reg),
        .result           (frame_result)
    );

    fhc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .result_in  (frame_result),
        .out_stall  (out_stall),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .result_out (out_result)
    );

    assign status         = out_result.status;
    assign frame_type     = out_result.frame_type;
    assign frame_flags    = out_result.frame_flags;
    assign payload_length = out_result.payload_length;
    assign declared_crc   = out_result.declared_crc;
    assign frame_sequence = out_result.frame_sequence;

    // Input side stalls only while a byte is held
    a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> held_valid)
        else $error("input stalled with no byte held");

    // A report is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid || !out_stall))
        else $error("report overwritten while stalled");

    // A report appears only after a frame's last byte was taken
    a_report_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(load))
        else $error("report without a last byte");

    // Status code is one of the defined codes whenever a report is valid
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= 3'(fhc_pkg::ST_CRC)))
        else $error("undefined status code");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the frame header checker with payload CRC-32.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 115;
    localparam int PHASE_FRAMES = 3;
    localparam int EXPECT_DEPTH = 16;

    // Index with no register behind it; writes to it must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One frame to send: header contents, how much of it goes out, payload size
    typedef struct packed {
        logic             extreme_cfg;   // reload registers with extreme values first
        logic [4:0]       hdr_bytes;     // header bytes sent; below 28 means short frame
        logic [7:0]       pay_bytes;     // payload bytes actually sent
        logic [31:0]      magic;
        logic [15:0]      version;
        logic [15:0]      ftype;
        logic [15:0]      flags;
        logic [31:0]      length;
        logic [63:0]      seq_no;
        logic             bad_crc;       // corrupt the carried CRC
        logic             typed;         // expected report given in the row
        fhc_pkg::status_t status;
    } frame_row_t;

    // Directed frames: extremes, each status code and the priority between them
    localparam frame_row_t DIRECTED [23] = '{
        '{1'b0, 5'd1,  8'd0,  32'h0000_0000, 16'd1, 16'd1, 16'h0000, 32'd0,
          64'd0, 1'b0, 1'b1, fhc_pkg::ST_TRUNC},
        '{1'b0, 5'd4,  8'd0,  32'h0000_00FF, 16'd1, 16'd1, 16'h0000, 32'd0,
          64'd0, 1'b0, 1'b1, fhc_pkg::ST_TRUNC},
        '{1'b0, 5'd27, 8'd0,  32'h0000_0000, 16'd1, 16'd2, 16'h00A5, 32'd0,
          64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, fhc_pkg::ST_OK},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'd1, 16'd1, 16'h0000, 32'd0,
          64'd0, 1'b0, 1'b1, fhc_pkg::ST_OK},
        '{1'b0, 5'd28, 8'd5,  32'h0000_0000, 16'd1, 16'd9, 16'h8001, 32'd5,
          64'd1, 1'b0, 1'b1, fhc_pkg::ST_OK},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0100, 16'd1, 16'd1, 16'h0000, 32'd0,
          64'd2, 1'b0, 1'b1, fhc_pkg::ST_MAGIC},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'd2, 16'd1, 16'h0000, 32'd0,
          64'd3, 1'b0, 1'b1, fhc_pkg::ST_VERSION},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'd1, 16'd0, 16'h0000, 32'd0,
          64'd4, 1'b0, 1'b1, fhc_pkg::ST_TYPE},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'd1, 16'd10, 16'h0000, 32'd0,
          64'd5, 1'b0, 1'b1, fhc_pkg::ST_TYPE},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'd1, 16'hFFFF, 16'hFFFF, 32'd0,
          64'd6, 1'b0, 1'b1, fhc_pkg::ST_TYPE},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'd1, 16'd1, 16'h0000, 32'd1048577,
          64'd7, 1'b0, 1'b1, fhc_pkg::ST_OVERSIZE},
        '{1'b0, 5'd28, 8'd3,  32'h0000_0000, 16'd1, 16'd1, 16'h0000, 32'd1048576,
          64'd8, 1'b0, 1'b1, fhc_pkg::ST_TRUNC},
        '{1'b0, 5'd28, 8'd6,  32'h0000_0000, 16'd1, 16'd2, 16'h0000, 32'd4,
          64'd9, 1'b0, 1'b1, fhc_pkg::ST_TRUNC},
        '{1'b0, 5'd28, 8'd4,  32'h0000_0000, 16'd1, 16'd3, 16'h0000, 32'd4,
          64'd10, 1'b1, 1'b1, fhc_pkg::ST_CRC},
        '{1'b0, 5'd28, 8'd0,  32'h0100_0000, 16'd0, 16'd0, 16'h0000, 32'd0,
          64'd11, 1'b0, 1'b1, fhc_pkg::ST_MAGIC},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'hFFFF, 16'd1, 16'h0000, 32'd0,
          64'd12, 1'b0, 1'b1, fhc_pkg::ST_VERSION},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'd1, 16'd1, 16'h0000, 32'hFFFF_FFFF,
          64'd13, 1'b0, 1'b1, fhc_pkg::ST_OVERSIZE},
        '{1'b0, 5'd28, 8'd16, 32'h0000_0000, 16'd1, 16'd3, 16'hFFFF, 32'd16,
          64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, fhc_pkg::ST_OK},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'd1, 16'd4, 16'h0000, 32'd2,
          64'd14, 1'b0, 1'b1, fhc_pkg::ST_TRUNC},
        '{1'b1, 5'd28, 8'd0,  32'hFFFF_FFFF, 16'hFFFF, 16'd5, 16'h0000, 32'd0,
          64'd15, 1'b0, 1'b1, fhc_pkg::ST_OK},
        '{1'b0, 5'd28, 8'd1,  32'hFFFF_FFFF, 16'hFFFF, 16'd5, 16'h0000, 32'd1,
          64'd16, 1'b0, 1'b1, fhc_pkg::ST_OVERSIZE},
        '{1'b0, 5'd28, 8'd0,  32'h0000_0000, 16'hFFFF, 16'd5, 16'h0000, 32'd0,
          64'd17, 1'b0, 1'b1, fhc_pkg::ST_MAGIC},
        '{1'b0, 5'd12, 8'd0,  32'hFFFF_FFFF, 16'hFFFF, 16'd7, 16'h1234, 32'd100,
          64'd18, 1'b0, 1'b0, fhc_pkg::ST_OK}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [15:0] frame_type;
    logic [15:0] frame_flags;
    logic [31:0] payload_length;
    logic [31:0] declared_crc;
    logic [63:0] frame_sequence;

    // Register copies
    logic [31:0] cfg_magic = fhc_pkg::MAGIC_RESET;
    logic [15:0] cfg_version = fhc_pkg::VERSION_RESET;
    logic [31:0] cfg_max_payload = fhc_pkg::MAX_PAYLOAD_RESET;

    // Frame state of the predictor
    logic [4:0]  hdr_pos;
    logic        magic_mismatch;
    logic [15:0] seen_version;
    logic [15:0] seen_type;
    logic [15:0] seen_flags;
    logic [31:0] seen_length;
    logic [31:0] seen_crc;
    logic [63:0] seen_sequence;
    logic [31:0] pay_crc;
    logic [32:0] pay_count;

    // Expected reports, oldest first; written by the sender, read by the checker
    fhc_pkg::result_t expect_buf [EXPECT_DEPTH];
    int               expect_wr = 0;
    int               expect_rd = 0;
    fhc_pkg::result_t oldest_report;
    fhc_pkg::result_t typed_report;
    logic             typed_pending = 1'b0;

    int          fail_count = 0;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_left = 0;
    logic        hold_start = 1'b0;
    logic        hold_taken = 1'b0;

    frame_header_check_crc32_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .frame_type     (frame_type),
        .frame_flags    (frame_flags),
        .payload_length (payload_length),
        .declared_crc   (declared_crc),
        .frame_sequence (frame_sequence)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bit-serial reflected CRC-32 over one byte
    function automatic logic [31:0] crc_step(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        int          k;
        c = crc_in;
        for (k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (fhc_pkg::CRC_POLY & {32{c[0] ^ b[k]}});
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        hdr_pos        = '0;
        magic_mismatch = 1'b0;
        seen_version   = '0;
        seen_type      = '0;
        seen_flags     = '0;
        seen_length    = '0;
        seen_crc       = '0;
        seen_sequence  = '0;
        pay_crc        = fhc_pkg::CRC_INIT;
        pay_count      = '0;
    endtask

    // Fold one accepted byte into the frame state; on the last byte queue the report
    task automatic advance_frame_check(input logic [7:0] b, input logic last);
        int               pos;
        fhc_pkg::result_t rep;
        pos = int'(hdr_pos);
        if (hdr_pos < fhc_pkg::HDR_BYTES)
        begin
            if (hdr_pos < fhc_pkg::POS_VERSION)
            begin
                if (b != cfg_magic[8*pos +: 8])
                    magic_mismatch = 1'b1;
            end
            else if (hdr_pos < fhc_pkg::POS_TYPE)
                seen_version[8*(pos - int'(fhc_pkg::POS_VERSION)) +: 8] = b;
            else if (hdr_pos < fhc_pkg::POS_FLAGS)
                seen_type[8*(pos - int'(fhc_pkg::POS_TYPE)) +: 8] = b;
            else if (hdr_pos < fhc_pkg::POS_RESERVED)
                seen_flags[8*(pos - int'(fhc_pkg::POS_FLAGS)) +: 8] = b;
            else if (hdr_pos < fhc_pkg::POS_LENGTH)
            begin
                // reserved bytes carry nothing
            end
            else if (hdr_pos < fhc_pkg::POS_CRC)
                seen_length[8*(pos - int'(fhc_pkg::POS_LENGTH)) +: 8] = b;
            else if (hdr_pos < fhc_pkg::POS_SEQUENCE)
                seen_crc[8*(pos - int'(fhc_pkg::POS_CRC)) +: 8] = b;
            else
                seen_sequence[8*(pos - int'(fhc_pkg::POS_SEQUENCE)) +: 8] = b;
            hdr_pos = hdr_pos + 5'd1;
        end
        else
        begin
            pay_crc = crc_step(pay_crc, b);
            if (pay_count != fhc_pkg::COUNT_MAX)
                pay_count = pay_count + 33'd1;
        end

        if (last)
        begin
            // First failing rule wins
            if (hdr_pos < fhc_pkg::HDR_BYTES)
                rep.status = fhc_pkg::ST_TRUNC;
            else if (magic_mismatch)
                rep.status = fhc_pkg::ST_MAGIC;
            else if (seen_version != cfg_version)
                rep.status = fhc_pkg::ST_VERSION;
            else if (seen_type < fhc_pkg::TYPE_MIN || seen_type > fhc_pkg::TYPE_MAX)
                rep.status = fhc_pkg::ST_TYPE;
            else if (seen_length > cfg_max_payload)
                rep.status = fhc_pkg::ST_OVERSIZE;
            else if (pay_count != {1'b0, seen_length})
                rep.status = fhc_pkg::ST_TRUNC;
            else if (~pay_crc != seen_crc)
                rep.status = fhc_pkg::ST_CRC;
            else
                rep.status = fhc_pkg::ST_OK;
            rep.frame_type     = seen_type;
            rep.frame_flags    = seen_flags;
            rep.payload_length = seen_length;
            rep.declared_crc   = seen_crc;
            rep.frame_sequence = seen_sequence;
            if (typed_pending)
            begin
                expect_buf[expect_wr % EXPECT_DEPTH] = typed_report;
                typed_pending = 1'b0;
            end
            else
                expect_buf[expect_wr % EXPECT_DEPTH] = rep;
            expect_wr++;
            clear_frame_state();
        end
    endtask

    // Offer one byte, with random idle cycles ahead of it, and hold it until transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        frame_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        advance_frame_check(b, last);
    endtask

    // Build the header and payload of one frame and send it
    task automatic send_frame(input frame_row_t f);
        logic [7:0]   pay [256];
        logic [223:0] hdr_bits;
        logic [31:0]  crc;
        logic [31:0]  carried_crc;
        logic [15:0]  reserved_bits;
        logic [7:0]   b;
        int           i;
        int           total;
        crc = fhc_pkg::CRC_INIT;
        for (i = 0; i < int'(f.pay_bytes); i++)
        begin
            pay[i] = 8'($urandom_range(0, 255));
            crc = crc_step(crc, pay[i]);
        end
        carried_crc = ~crc;
        if (f.bad_crc)
            carried_crc = carried_crc ^ (32'd1 << $urandom_range(0, 31));
        reserved_bits = 16'($urandom);
        hdr_bits = {f.seq_no, carried_crc, f.length, reserved_bits,
                    f.flags, f.ftype, f.version, f.magic};

        if (f.typed)
        begin
            typed_report        = '0;
            typed_report.status = f.status;
            if (f.hdr_bytes == fhc_pkg::HDR_BYTES)
            begin
                typed_report.frame_type     = f.ftype;
                typed_report.frame_flags    = f.flags;
                typed_report.payload_length = f.length;
                typed_report.declared_crc   = carried_crc;
                typed_report.frame_sequence = f.seq_no;
            end
            typed_pending = 1'b1;
        end

        if (f.hdr_bytes < fhc_pkg::HDR_BYTES)
            total = int'(f.hdr_bytes);
        else
            total = int'(fhc_pkg::HDR_BYTES) + int'(f.pay_bytes);
        for (i = 0; i < total; i++)
        begin
            if (i < int'(fhc_pkg::HDR_BYTES))
                b = hdr_bits[8*i +: 8];
            else
                b = pay[i - int'(fhc_pkg::HDR_BYTES)];
            send_byte(b, i == total - 1);
        end
        frames_sent++;
    endtask

    // Random frame: mostly well formed against the current registers
    function automatic frame_row_t random_frame();
        frame_row_t  f;
        int          pick;
        logic [31:0] len_cap;
        f           = '0;
        f.hdr_bytes = fhc_pkg::HDR_BYTES;
        f.magic     = cfg_magic;
        f.version   = cfg_version;
        f.ftype     = 16'($urandom_range(1, 9));
        f.flags     = 16'($urandom);
        f.seq_no    = {$urandom, $urandom};
        if (cfg_max_payload < 32'd16)
            len_cap = cfg_max_payload;
        else if (cfg_max_payload >= 32'd48 && $urandom_range(0, 9) == 0)
            len_cap = 32'd48;
        else
            len_cap = 32'd16;
        f.length    = $urandom_range(0, len_cap);
        f.pay_bytes = f.length[7:0];

        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            // well formed
        end
        else if (pick < 65)
        begin
            // short frame with random content
            f.hdr_bytes = 5'($urandom_range(1, 27));
            f.magic     = $urandom;
            f.version   = 16'($urandom);
            f.ftype     = 16'($urandom);
            f.length    = $urandom;
            f.seq_no    = {$urandom, $urandom};
        end
        else if (pick < 70)
            f.magic = f.magic ^ (32'd1 << $urandom_range(0, 31));
        else if (pick < 75)
            f.version = f.version ^ 16'($urandom_range(1, 65535));
        else if (pick < 80)
        begin
            if ($urandom_range(0, 3) == 0)
                f.ftype = 16'd0;
            else
                f.ftype = 16'($urandom_range(10, 65535));
        end
        else if (pick < 85)
        begin
            // declared length over the limit, where the limit leaves room
            if (cfg_max_payload != '1)
            begin
                if ($urandom_range(0, 1) == 0)
                    f.length = cfg_max_payload + 32'd1;
                else
                    f.length = cfg_max_payload + 32'($urandom_range(2, 1000));
                if (f.length <= cfg_max_payload)
                    f.length = '1;
                f.pay_bytes = 8'($urandom_range(0, 4));
            end
        end
        else if (pick < 90)
        begin
            f.pay_bytes = 8'($urandom_range(0, 20));
            if ({24'd0, f.pay_bytes} == f.length)
                f.pay_bytes = f.pay_bytes + 8'd1;
        end
        else if (pick < 95)
            f.bad_crc = 1'b1;
        else
        begin
            // noise header
            if ($urandom_range(0, 1) == 0)
                f.magic = $urandom;
            f.version   = 16'($urandom);
            f.ftype     = 16'($urandom);
            if ($urandom_range(0, 1) == 0)
                f.length = $urandom;
            else
                f.length = $urandom_range(0, 12);
            f.pay_bytes = 8'($urandom_range(0, 12));
        end
        return f;
    endfunction

    task automatic put_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write all registers, the unused index too, then update the copies
    task automatic load_config(input logic [31:0] magic,
                               input logic [15:0] version,
                               input logic [31:0] max_payload);
        logic [15:0] upper;
        upper = 16'($urandom);
        put_reg(fhc_pkg::CFG_MAGIC, magic);
        put_reg(fhc_pkg::CFG_VERSION, {upper, version});
        put_reg(fhc_pkg::CFG_MAX_PAYLOAD, max_payload);
        put_reg(CFG_UNUSED, $urandom);
        cfg_write       <= 1'b0;
        cfg_magic       = magic;
        cfg_version     = version;
        cfg_max_payload = max_payload;
    endtask

    // Stop offering and let every report come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expect_wr != expect_rd)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int         i;
        int         p;
        int         start_bytes;
        int         start_frames;
        idle_mode_t mode;
        clear_frame_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].extreme_cfg)
            begin
                wait_idle();
                load_config('1, 16'hFFFF, 32'd0);
            end
            send_frame(DIRECTED[i]);
        end

        for (p = 0; p < 4; p++)
        begin
            mode = idle_mode_t'(p);
            wait_idle();
            case (mode)
                IDLE_NONE:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                    load_config($urandom, 16'($urandom), 32'($urandom_range(4, 40)));
                end
                IDLE_SENDER:
                begin
                    tx_idle_pct = 45;
                    rx_stall_pct <= 0;
                    load_config(32'd0, 16'd0, '1);
                end
                IDLE_RECEIVER:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 45;
                    load_config($urandom, 16'($urandom), $urandom);
                    // long hold-off so the block backs up into its input
                    hold_start <= 1'b1;
                end
                default:
                begin
                    tx_idle_pct = 13;
                    rx_stall_pct <= 13;
                    load_config($urandom, fhc_pkg::VERSION_RESET,
                                fhc_pkg::MAX_PAYLOAD_RESET);
                end
            endcase
            start_bytes  = bytes_sent;
            start_frames = frames_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES ||
                   frames_sent - start_frames < PHASE_FRAMES)
                send_frame(random_frame());
        end

        wait_idle();
        if (fail_count == 0 && expect_wr == expect_rd)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver stall, with one counted hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_start && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Compare each report transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expect_wr == expect_rd)
            begin
                $error("report transfer with none expected, status field %0d", status);
                fail_count++;
            end
            else
            begin
                oldest_report = expect_buf[expect_rd % EXPECT_DEPTH];
                expect_rd++;
                if (status !== oldest_report.status)
                begin
                    $error("field status expected %0d got %0d",
                           oldest_report.status, status);
                    fail_count++;
                end
                if (frame_type !== oldest_report.frame_type)
                begin
                    $error("field frame_type expected %h got %h",
                           oldest_report.frame_type, frame_type);
                    fail_count++;
                end
                if (frame_flags !== oldest_report.frame_flags)
                begin
                    $error("field frame_flags expected %h got %h",
                           oldest_report.frame_flags, frame_flags);
                    fail_count++;
                end
                if (payload_length !== oldest_report.payload_length)
                begin
                    $error("field payload_length expected %h got %h",
                           oldest_report.payload_length, payload_length);
                    fail_count++;
                end
                if (declared_crc !== oldest_report.declared_crc)
                begin
                    $error("field declared_crc expected %h got %h",
                           oldest_report.declared_crc, declared_crc);
                    fail_count++;
                end
                if (frame_sequence !== oldest_report.frame_sequence)
                begin
                    $error("field frame_sequence expected %h got %h",
                           oldest_report.frame_sequence, frame_sequence);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
